### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property at every rising edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// implication form, same clocking
`define ASSERT_IMP(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

`endif

### rtl/pvc_pkg.sv
// ---------------------------------------------------------------------------
// pvc_pkg
// shared types and constants of the particle verlet and collider pipeline
// ---------------------------------------------------------------------------
package pvc_pkg;

  localparam int FRACTION_BITS = 16;
  localparam int C_W           = 24;   // coordinate width
  localparam int SQ_IN_W       = 46;   // radicand width (below r squared)
  localparam int SQ_ROOT_W     = SQ_IN_W / 2;
  localparam int DIV_DEN_W     = 23;
  localparam int DIV_Q_W       = 24;
  localparam int DIV_NUM_W     = DIV_DEN_W + DIV_Q_W;
  localparam int FRONT_STAGES  = 6;
  localparam int SIDE_DEPTH    = SQ_ROOT_W + 2 + DIV_Q_W;
  localparam int LATENCY       = FRONT_STAGES + SIDE_DEPTH;

  typedef logic signed [C_W-1:0] coord_t;

  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_SPHERE = 2'd1,
    MODE_CUBE   = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CONTACT_NONE   = 2'd0,
    CONTACT_SPHERE = 2'd1,
    CONTACT_CUBE   = 2'd2,
    CONTACT_CENTRE = 2'd3
  } contact_t;

  typedef enum logic [2:0] {
    REG_GRAVITY_X   = 3'd0,
    REG_GRAVITY_Y   = 3'd1,
    REG_GRAVITY_Z   = 3'd2,
    REG_STEP_SQ     = 3'd3,
    REG_SPHERE_R    = 3'd4,
    REG_CUBE_H      = 3'd5,
    REG_MODE        = 3'd6,
    REG_NONE        = 3'd7
  } reg_index_t;

  typedef struct packed {
    coord_t               pos_x;
    coord_t               pos_y;
    coord_t               pos_z;
    coord_t               prev_x;
    coord_t               prev_y;
    coord_t               prev_z;
    logic [C_W-1:0]       inv_mass;
  } in_word_t;

  typedef struct packed {
    coord_t               new_x;
    coord_t               new_y;
    coord_t               new_z;
    coord_t               old_x;
    coord_t               old_y;
    coord_t               old_z;
    logic [1:0]           contact;
    logic                 saturated;
  } out_word_t;

endpackage

### rtl/particle_verlet_collide.sv
// ---------------------------------------------------------------------------
// particle_verlet_collide
// verlet step of one particle with sphere or cube collider at the origin
// ---------------------------------------------------------------------------
// an accepted word passes the front stages, then the side line, to its out_valid strobe
// throughput: one word per cycle while busy is low, the pipeline never stalls
// depth set by the 23-stage square root and 24-stage divider lanes
// reset: synchronous, active low; registers take their defaults,
// busy is high during reset and clears at the first edge with rst_n high
module particle_verlet_collide import pvc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // input words
  input  logic        start,
  output logic        busy,
  input  in_word_t    in_data,
  // result words, one cycle strobe
  output logic        out_valid,
  output out_word_t   out_data,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam logic signed [49:0] ROUND_A = 50'sd1 <<< (FRACTION_BITS - 1);
  localparam logic signed [49:0] ACC_MAX = 50'sd2147483647;
  localparam logic signed [49:0] ACC_MIN = -50'sd2147483648;
  localparam logic signed [65:0] ROUND_D = 66'sd1 <<< 31;
  localparam logic signed [65:0] C_MAX   = 66'sd8388607;
  localparam logic signed [65:0] C_MIN   = -66'sd8388608;

  // -------------------------------------------------------------------------
  // configuration registers
  // -------------------------------------------------------------------------
  coord_t                gx_r, gy_r, gz_r;
  logic [31:0]           step_sq_r;
  logic [DIV_DEN_W-1:0]  radius_r;
  logic [DIV_DEN_W-1:0]  half_r;
  mode_t                 mode_r;
  logic                  busy_r;
  reg_index_t            cfg_sel;

  assign cfg_ready = 1'b1;
  assign cfg_sel   = reg_index_t'(cfg_index);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gx_r      <= '0;
      gy_r      <= -24'sd32768;
      gz_r      <= '0;
      step_sq_r <= 32'd429497;
      radius_r  <= 23'd65536;
      half_r    <= 23'd65536;
      mode_r    <= MODE_NONE;
      busy_r    <= 1'b1;
    end else begin
      busy_r <= 1'b0;
      if (cfg_valid) begin
        unique case (cfg_sel)
          REG_GRAVITY_X: gx_r      <= cfg_data[C_W-1:0];
          REG_GRAVITY_Y: gy_r      <= cfg_data[C_W-1:0];
          REG_GRAVITY_Z: gz_r      <= cfg_data[C_W-1:0];
          REG_STEP_SQ:   step_sq_r <= cfg_data;
          REG_SPHERE_R:  radius_r  <= cfg_data[DIV_DEN_W-1:0];
          REG_CUBE_H:    half_r    <= cfg_data[DIV_DEN_W-1:0];
          REG_MODE:      mode_r    <= mode_t'(cfg_data[1:0]);
          REG_NONE:      ;
          default:       ;
        endcase
      end
    end
  end

  assign busy = busy_r;

  logic in_fire;
  assign in_fire = start && !busy_r;

  coord_t g_vec [3];
  coord_t p_in  [3];
  coord_t q_in  [3];
  assign g_vec[0] = gx_r;
  assign g_vec[1] = gy_r;
  assign g_vec[2] = gz_r;
  assign p_in[0]  = in_data.pos_x;
  assign p_in[1]  = in_data.pos_y;
  assign p_in[2]  = in_data.pos_z;
  assign q_in[0]  = in_data.prev_x;
  assign q_in[1]  = in_data.prev_y;
  assign q_in[2]  = in_data.prev_z;

  // valid bits of stages 1 to 5
  logic [FRONT_STAGES-2:0] vld_r;

  // stage 1: gravity times inverse mass
  logic signed [48:0] s1_prod_r [3];
  coord_t             s1_p_r    [3];
  coord_t             s1_q_r    [3];

  // stage 2: rounded and clamped acceleration
  logic signed [31:0] s2_acc_r  [3];
  coord_t             s2_p_r    [3];
  coord_t             s2_q_r    [3];

  // stage 3: acceleration times step squared
  logic signed [64:0] s3_prod_r [3];
  coord_t             s3_p_r    [3];
  coord_t             s3_q_r    [3];

  // stage 4: verlet position, clamped
  coord_t             s4_n_r    [3];
  coord_t             s4_p_r    [3];
  logic               s4_sat_r;

  // stage 5: squares and magnitudes
  logic [46:0]        s5_sq_r   [3];
  logic [C_W-1:0]     s5_abs_r  [3];
  coord_t             s5_n_r    [3];
  coord_t             s5_p_r    [3];
  logic               s5_sat_r;
  logic [45:0]        s5_r2_r;

  // stage 6 and the side line carry the word past the root and divider
  typedef struct packed {
    logic                 vld;
    coord_t [2:0]         n;
    coord_t [2:0]         o;
    logic [1:0]           contact;
    logic                 sat;
    logic                 push;
  } side_t;

  side_t              side_r [SIDE_DEPTH];
  side_t              s6_nxt;
  logic [SQ_IN_W-1:0] l2_r;

  logic signed [49:0] s2_t   [3];
  logic signed [49:0] s2_sh  [3];
  logic signed [65:0] s4_t   [3];
  logic signed [65:0] s4_v   [3];
  logic               s4_sat [3];
  coord_t             s4_c   [3];

  for (genvar k = 0; k < 3; k++) begin : g_axis
    assign s2_t[k]  = 50'(s1_prod_r[k]) + ROUND_A;
    assign s2_sh[k] = s2_t[k] >>> FRACTION_BITS;

    assign s4_t[k] = 66'(s3_prod_r[k]) + ROUND_D;
    assign s4_v[k] = 66'(s4_t[k] >>> 32)
                   + (66'(s3_p_r[k]) <<< 1) - 66'(s3_q_r[k]);

    always_comb begin
      s4_sat[k] = 1'b1;
      priority if (s4_v[k] > C_MAX) s4_c[k] = coord_t'(C_MAX);
      else if (s4_v[k] < C_MIN)     s4_c[k] = coord_t'(C_MIN);
      else begin
        s4_c[k]   = coord_t'(s4_v[k]);
        s4_sat[k] = 1'b0;
      end
    end

    always_ff @(posedge clk) begin
      // stage 1
      s1_prod_r[k] <= g_vec[k] * $signed({1'b0, in_data.inv_mass});
      s1_p_r[k]    <= p_in[k];
      s1_q_r[k]    <= q_in[k];
      // stage 2
      priority if (s2_sh[k] > ACC_MAX) s2_acc_r[k] <= 32'(ACC_MAX);
      else if (s2_sh[k] < ACC_MIN)     s2_acc_r[k] <= 32'(ACC_MIN);
      else                             s2_acc_r[k] <= 32'(s2_sh[k]);
      s2_p_r[k] <= s1_p_r[k];
      s2_q_r[k] <= s1_q_r[k];
      // stage 3
      s3_prod_r[k] <= s2_acc_r[k] * $signed({1'b0, step_sq_r});
      s3_p_r[k]    <= s2_p_r[k];
      s3_q_r[k]    <= s2_q_r[k];
      // stage 4
      s4_n_r[k] <= s4_c[k];
      s4_p_r[k] <= s3_p_r[k];
      // stage 5, square formed at full width
      s5_sq_r[k]  <= 47'(48'(s4_n_r[k]) * 48'(s4_n_r[k]));
      s5_abs_r[k] <= s4_n_r[k][C_W-1] ? C_W'(-s4_n_r[k]) : C_W'(s4_n_r[k]);
      s5_n_r[k]   <= s4_n_r[k];
      s5_p_r[k]   <= s4_p_r[k];
    end
  end

  always_ff @(posedge clk) begin
    s4_sat_r <= s4_sat[0] | s4_sat[1] | s4_sat[2];
    s5_sat_r <= s4_sat_r;
    s5_r2_r  <= radius_r * radius_r;
  end

  // -------------------------------------------------------------------------
  // stage 6: collider decisions
  // -------------------------------------------------------------------------
  logic [47:0]        l2_sum;
  logic signed [24:0] face_d [3];
  logic               sph_in;
  logic               cube_in;
  logic [1:0]         axis;
  coord_t             half_s;

  assign l2_sum = 48'(s5_sq_r[0]) + 48'(s5_sq_r[1]) + 48'(s5_sq_r[2]);
  assign half_s = coord_t'({1'b0, half_r});
  for (genvar k = 0; k < 3; k++) begin : g_dist
    assign face_d[k] = $signed({1'b0, s5_abs_r[k]}) - $signed({2'b00, half_r});
  end
  assign sph_in  = (mode_r == MODE_SPHERE) && (l2_sum < 48'(s5_r2_r));
  assign cube_in = (mode_r == MODE_CUBE) && (face_d[0] <= 0) && (face_d[1] <= 0)
                && (face_d[2] <= 0);

  // nearest face, ties go to y, then x, then z
  always_comb begin
    priority if (face_d[1] >= face_d[0] && face_d[1] >= face_d[2]) axis = 2'd1;
    else if (face_d[0] >= face_d[2])                               axis = 2'd0;
    else                                                           axis = 2'd2;
  end

  always_comb begin
    s6_nxt.vld     = vld_r[FRONT_STAGES-2];
    s6_nxt.sat     = s5_sat_r;
    s6_nxt.push    = 1'b0;
    s6_nxt.contact = CONTACT_NONE;
    for (int k = 0; k < 3; k++) begin
      s6_nxt.n[k] = s5_n_r[k];
      s6_nxt.o[k] = s5_p_r[k];
    end
    if (sph_in) begin
      if (l2_sum == '0) s6_nxt.contact = CONTACT_CENTRE;
      else              s6_nxt.push    = 1'b1;
    end else if (cube_in) begin
      s6_nxt.contact = CONTACT_CUBE;
      s6_nxt.n[axis] = (s5_n_r[axis] <= 0) ? -half_s : half_s;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[FRONT_STAGES-3:0], in_fire};
    end
  end

  // the side line: element 0 is stage 6
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SIDE_DEPTH; i++) side_r[i].vld <= 1'b0;
    end else begin
      side_r[0] <= s6_nxt;
      for (int i = 1; i < SIDE_DEPTH; i++) side_r[i] <= side_r[i-1];
    end
    l2_r <= l2_sum[SQ_IN_W-1:0];
  end

  // -------------------------------------------------------------------------
  // radial push: len = isqrt(l2), mag = (|c| * r + len / 2) / len
  // -------------------------------------------------------------------------
  logic [SQ_ROOT_W-1:0] root;
  logic [DIV_NUM_W-1:0] num_r [3];
  logic [DIV_DEN_W-1:0] len_r;
  logic [DIV_Q_W-1:0]   quot  [3];

  pvc_isqrt u_isqrt (
    .clk    (clk),
    .v_i    (l2_r),
    .root_o (root)
  );

  // root lines up with side element SQ_ROOT_W
  for (genvar k = 0; k < 3; k++) begin : g_lane
    logic [C_W-1:0] mag_in;
    assign mag_in = side_r[SQ_ROOT_W].n[k][C_W-1]
                  ? C_W'(-side_r[SQ_ROOT_W].n[k])
                  : C_W'(side_r[SQ_ROOT_W].n[k]);

    always_ff @(posedge clk) begin
      num_r[k] <= DIV_NUM_W'(mag_in) * DIV_NUM_W'(radius_r) + DIV_NUM_W'(root >> 1);
    end

    pvc_divider u_div (
      .clk    (clk),
      .num_i  (num_r[k]),
      .den_i  (len_r),
      .quot_o (quot[k])
    );
  end

  always_ff @(posedge clk) begin
    len_r <= root;
  end

  // -------------------------------------------------------------------------
  // output register
  // -------------------------------------------------------------------------
  side_t  last;
  coord_t fin_n [3];
  coord_t fin_o [3];
  logic   out_valid_r;
  out_word_t out_data_r;

  assign last = side_r[SIDE_DEPTH-1];

  for (genvar k = 0; k < 3; k++) begin : g_fin
    coord_t mag_s;
    assign mag_s    = coord_t'(quot[k]);
    assign fin_n[k] = last.push ? (last.n[k][C_W-1] ? -mag_s : mag_s) : last.n[k];
    assign fin_o[k] = last.push ? fin_n[k] : last.o[k];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= last.vld;
    end
    out_data_r.new_x     <= fin_n[0];
    out_data_r.new_y     <= fin_n[1];
    out_data_r.new_z     <= fin_n[2];
    out_data_r.old_x     <= fin_o[0];
    out_data_r.old_y     <= fin_o[1];
    out_data_r.old_z     <= fin_o[2];
    out_data_r.contact   <= last.push ? CONTACT_SPHERE : last.contact;
    out_data_r.saturated <= last.sat;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // -------------------------------------------------------------------------
  // assertions
  // -------------------------------------------------------------------------
`include "assert_macros.svh"

  // every accepted word comes out after the fixed latency, and only then
  `ASSERT_CLK(a_latency, clk, rst_n, out_valid == $past(in_fire, LATENCY))
  // a radial push moves prev along with the point
  `ASSERT_IMP(a_push_old, clk, rst_n,
              out_valid && out_data.contact == CONTACT_SPHERE,
              out_data.old_x == out_data.new_x && out_data.old_y == out_data.new_y
              && out_data.old_z == out_data.new_z)
  // a face push only happens under the cube mode
  `ASSERT_IMP(a_cube_mode, clk, rst_n,
              out_valid && out_data.contact == CONTACT_CUBE, mode_r == MODE_CUBE)

endmodule

### rtl/pvc_isqrt.sv
// ---------------------------------------------------------------------------
// pvc_isqrt
// pipelined integer square root, one result bit per stage
// ---------------------------------------------------------------------------
module pvc_isqrt import pvc_pkg::*; (
  input  logic                 clk,
  input  logic [SQ_IN_W-1:0]   v_i,
  output logic [SQ_ROOT_W-1:0] root_o
);

  localparam int RW = SQ_ROOT_W + 2;

  logic [SQ_IN_W-1:0]   val_r  [SQ_ROOT_W];
  logic [SQ_ROOT_W-1:0] root_r [SQ_ROOT_W];
  logic [RW-1:0]        rem_r  [SQ_ROOT_W];

  for (genvar i = 0; i < SQ_ROOT_W; i++) begin : g_stage
    logic [SQ_IN_W-1:0]   src_val;
    logic [SQ_ROOT_W-1:0] src_root;
    logic [RW-1:0]        src_rem;
    logic [RW+1:0]        rem_t;
    logic [RW+1:0]        trial;

    if (i == 0) begin : g_first
      assign src_val  = v_i;
      assign src_root = '0;
      assign src_rem  = '0;
    end else begin : g_next
      assign src_val  = val_r[i-1];
      assign src_root = root_r[i-1];
      assign src_rem  = rem_r[i-1];
    end

    assign rem_t = {src_rem, src_val[SQ_IN_W-1 -: 2]};
    assign trial = {2'b00, src_root, 2'b01};

    always_ff @(posedge clk) begin
      val_r[i] <= {src_val[SQ_IN_W-3:0], 2'b00};
      if (rem_t >= trial) begin
        rem_r[i]  <= RW'(rem_t - trial);
        root_r[i] <= {src_root[SQ_ROOT_W-2:0], 1'b1};
      end else begin
        rem_r[i]  <= RW'(rem_t);
        root_r[i] <= {src_root[SQ_ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign root_o = root_r[SQ_ROOT_W-1];

endmodule

### rtl/pvc_divider.sv
// ---------------------------------------------------------------------------
// pvc_divider
// pipelined restoring divider, one quotient bit per stage
// ---------------------------------------------------------------------------
module pvc_divider import pvc_pkg::*; (
  input  logic                 clk,
  input  logic [DIV_NUM_W-1:0] num_i,
  input  logic [DIV_DEN_W-1:0] den_i,
  output logic [DIV_Q_W-1:0]   quot_o
);

  // quotient is known to fit, so the upper numerator part starts below den
  logic [DIV_Q_W-1:0]   low_r  [DIV_Q_W];
  logic [DIV_DEN_W-1:0] den_r  [DIV_Q_W];
  logic [DIV_DEN_W-1:0] rem_r  [DIV_Q_W];
  logic [DIV_Q_W-1:0]   quot_r [DIV_Q_W];

  for (genvar i = 0; i < DIV_Q_W; i++) begin : g_stage
    logic [DIV_Q_W-1:0]   src_low;
    logic [DIV_DEN_W-1:0] src_den;
    logic [DIV_DEN_W-1:0] src_rem;
    logic [DIV_Q_W-1:0]   src_quot;
    logic [DIV_DEN_W:0]   rem_t;

    if (i == 0) begin : g_first
      assign src_low  = num_i[DIV_Q_W-1:0];
      assign src_den  = den_i;
      assign src_rem  = num_i[DIV_NUM_W-1:DIV_Q_W];
      assign src_quot = '0;
    end else begin : g_next
      assign src_low  = low_r[i-1];
      assign src_den  = den_r[i-1];
      assign src_rem  = rem_r[i-1];
      assign src_quot = quot_r[i-1];
    end

    assign rem_t = {src_rem, src_low[DIV_Q_W-1]};

    always_ff @(posedge clk) begin
      low_r[i] <= {src_low[DIV_Q_W-2:0], 1'b0};
      den_r[i] <= src_den;
      if (rem_t >= {1'b0, src_den}) begin
        rem_r[i]  <= DIV_DEN_W'(rem_t - {1'b0, src_den});
        quot_r[i] <= {src_quot[DIV_Q_W-2:0], 1'b1};
      end else begin
        rem_r[i]  <= DIV_DEN_W'(rem_t);
        quot_r[i] <= {src_quot[DIV_Q_W-2:0], 1'b0};
      end
    end
  end

  assign quot_o = quot_r[DIV_Q_W-1];

endmodule
